// File: sv/eig2_pkg.sv
// Shared constants for the 2x2 eigenvalue block.
// No dependencies; the interfaces and every module import this package.
`default_nettype none

package eig2_pkg;

  // Default entry width of one matrix element (signed Q8.8 by default)
  localparam int DEF_ENTRY_WIDTH = 16;

endpackage : eig2_pkg

`default_nettype wire

// File: sv/eig2_if.sv
// Valid/ready channels of the 2x2 eigenvalue block: matrix in, roots out.
// Depends on eig2_pkg for the default entry width.
`default_nettype none

interface eig2_in_if import eig2_pkg::*; #(
  parameter int W = DEF_ENTRY_WIDTH
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] entry_row0_col0;
  logic signed [W-1:0] entry_row0_col1;
  logic signed [W-1:0] entry_row1_col0;
  logic signed [W-1:0] entry_row1_col1;

  modport source (
    output valid, entry_row0_col0, entry_row0_col1, entry_row1_col0, entry_row1_col1,
    input  ready
  );
  modport sink (
    input  valid, entry_row0_col0, entry_row0_col1, entry_row1_col0, entry_row1_col1,
    output ready
  );
endinterface : eig2_in_if

interface eig2_out_if import eig2_pkg::*; #(
  parameter int W = DEF_ENTRY_WIDTH
);
  logic                valid;
  logic                ready;
  logic signed [W+1:0] first_root_real;
  logic signed [W+1:0] second_root_real;
  logic        [W:0]   imag_magnitude;
  logic                roots_are_real;

  modport source (
    output valid, first_root_real, second_root_real, imag_magnitude, roots_are_real,
    input  ready
  );
  modport sink (
    input  valid, first_root_real, second_root_real, imag_magnitude, roots_are_real,
    output ready
  );
endinterface : eig2_out_if

`default_nettype wire

// File: sv/eigenvalues_2x2_matrix.sv
// Top level: pipelined eigenvalues of a 2x2 fixed-point matrix.
// Depends on eig2_pkg and the channel interfaces in eig2_if.sv.
//
//  Channel | Dir | Interface   | Payload
//  --------+-----+-------------+------------------------------------------------
//  matrix  | in  | eig2_in_if  | entry_row0_col0/_col1, entry_row1_col0/_col1
//  roots   | out | eig2_out_if | first/second_root_real, imag_magnitude, real flag
//
// One item per cycle while the output is not stalled. The stages are: trace and products,
// t*t and determinant, discriminant magnitude, one square-root bit per stage
// (ENTRY_WIDTH + 1 stages), then the output register.
// rst is synchronous and clears only the stage valid bits.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// close up under output backpressure and no item is dropped or repeated.
`default_nettype none

module eigenvalues_2x2_matrix import eig2_pkg::*; #(
  parameter int ENTRY_WIDTH = DEF_ENTRY_WIDTH
) (
  input  logic         clk,
  input  logic         rst,
  eig2_in_if.sink      matrix,
  eig2_out_if.source   roots
);

  localparam int EW  = ENTRY_WIDTH;
  localparam int TW  = EW + 1;        // trace
  localparam int PW  = 2 * EW;        // entry product
  localparam int TTW = 2 * TW;        // trace squared
  localparam int DTW = PW + 1;        // determinant
  localparam int DW  = 2 * EW + 3;    // discriminant, signed
  localparam int NB  = EW + 1;        // root bits
  localparam int RW  = 2 * NB;        // radicand
  localparam int MW  = NB + 2;        // partial remainder
  localparam int CW  = NB + 4;        // remainder with next digit pair
  localparam int SW  = EW + 3;        // t +/- s before halving
  localparam int OW  = EW + 2;        // real part
  localparam int NS  = NB + 4;        // total stages

  // Stage valid bits and load enables
  logic [NS-1:0] v;
  logic [NS-1:0] en;

  assign en[NS-1] = ~v[NS-1] | roots.ready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_en
    assign en[k] = ~v[k] | en[k+1];
  end
  assign matrix.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= matrix.valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // Stage 0: trace and the two entry products
  logic signed [TW-1:0] s1_t;
  logic signed [PW-1:0] s1_p0;
  logic signed [PW-1:0] s1_p1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_t  <= TW'(matrix.entry_row0_col0) + TW'(matrix.entry_row1_col1);
      s1_p0 <= PW'(matrix.entry_row0_col0) * PW'(matrix.entry_row1_col1);
      s1_p1 <= PW'(matrix.entry_row0_col1) * PW'(matrix.entry_row1_col0);
    end
  end

  // Stage 1: trace squared and determinant
  logic signed [TW-1:0]  s2_t;
  logic signed [TTW-1:0] s2_tt;
  logic signed [DTW-1:0] s2_det;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_t   <= s1_t;
      s2_tt  <= TTW'(s1_t) * TTW'(s1_t);
      s2_det <= DTW'(s1_p0) - DTW'(s1_p1);
    end
  end

  // Stage 2: discriminant, sign and magnitude
  logic signed [DW-1:0] disc;
  logic        [DW-1:0] disc_mag;

  always_comb begin
    disc     = DW'(s2_tt) - (DW'(s2_det) <<< 2);
    disc_mag = disc[DW-1] ? DW'(-disc) : DW'(disc);
  end

  // Square-root pipeline; index 0 is the discriminant register
  logic signed [TW-1:0] q_t    [0:NB];
  logic                 q_neg  [0:NB];
  logic        [RW-1:0] q_rad  [0:NB];
  logic        [MW-1:0] q_rem  [0:NB];
  logic        [NB-1:0] q_root [0:NB];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      q_t[0]    <= s2_t;
      q_neg[0]  <= disc[DW-1];
      q_rad[0]  <= disc_mag[RW-1:0];
      q_rem[0]  <= '0;
      q_root[0] <= '0;
    end
  end

  // One root bit per stage, restoring digit recurrence
  for (genvar j = 0; j < NB; j++) begin : g_sqrt
    logic [CW-1:0] cur;
    logic [CW-1:0] trial;
    logic          take;

    always_comb begin
      cur   = {q_rem[j], q_rad[j][RW-1 -: 2]};
      trial = CW'({q_root[j], 2'b01});
      take  = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (en[j+3]) begin
        q_t[j+1]    <= q_t[j];
        q_neg[j+1]  <= q_neg[j];
        q_rad[j+1]  <= {q_rad[j][RW-3:0], 2'b00};
        q_rem[j+1]  <= take ? MW'(cur - trial) : MW'(cur);
        q_root[j+1] <= {q_root[j][NB-2:0], take};
      end
    end
  end

  // Output stage: roots from trace and square root
  logic signed [SW-1:0] t_ext;
  logic signed [SW-1:0] s_ext;
  logic signed [SW-1:0] lo_sum;
  logic signed [SW-1:0] hi_sum;
  logic signed [SW-1:0] t_half;

  always_comb begin
    t_ext  = SW'(q_t[NB]);
    s_ext  = $signed(SW'(q_root[NB]));
    lo_sum = (t_ext - s_ext) >>> 1;
    hi_sum = (t_ext + s_ext) >>> 1;
    t_half = t_ext >>> 1;
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      if (q_neg[NB]) begin
        roots.first_root_real  <= t_half[OW-1:0];
        roots.second_root_real <= t_half[OW-1:0];
        roots.imag_magnitude   <= {1'b0, q_root[NB][NB-1:1]};
        roots.roots_are_real   <= 1'b0;
      end else begin
        roots.first_root_real  <= lo_sum[OW-1:0];
        roots.second_root_real <= hi_sum[OW-1:0];
        roots.imag_magnitude   <= '0;
        roots.roots_are_real   <= 1'b1;
      end
    end
  end

  assign roots.valid = v[NS-1];

endmodule : eigenvalues_2x2_matrix

`default_nettype wire

// File: sv/eig2_checker.sv
// Port-level checks for the 2x2 eigenvalue block, bound to the top level.
// Depends on eig2_pkg for the default entry width.
`default_nettype none

module eig2_checker import eig2_pkg::*; #(
  parameter int W = DEF_ENTRY_WIDTH
) (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [W+1:0] first_root_real,
  input logic signed [W+1:0] second_root_real,
  input logic        [W:0]   imag_magnitude,
  input logic                roots_are_real
);

  // No result right after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result stays up
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Complex pair shares one real part
  a_complex: assert property (@(posedge clk) disable iff (rst)
    out_valid && !roots_are_real |-> first_root_real == second_root_real)
    else $error("complex pair with differing real parts");

  // Real roots: no imaginary part, ordered
  a_real: assert property (@(posedge clk) disable iff (rst)
    out_valid && roots_are_real |->
      imag_magnitude == '0 && first_root_real <= second_root_real)
    else $error("real roots misordered or with imaginary part");

endmodule : eig2_checker

bind eigenvalues_2x2_matrix eig2_checker #(.W(ENTRY_WIDTH)) u_eig2_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (roots.valid),
  .out_ready        (roots.ready),
  .first_root_real  (roots.first_root_real),
  .second_root_real (roots.second_root_real),
  .imag_magnitude   (roots.imag_magnitude),
  .roots_are_real   (roots.roots_are_real)
);

`default_nettype wire
